@@ rtl/gpb_pkg.sv @@
package gpb_pkg;

	// Ports that are mapped (1 to 8); storage always covers eight ports.
	localparam int PortCount = 8;
	localparam int PortSlots = 8;
	localparam int PortIdxW  = 3;

	localparam logic [1:0] OpRead  = 2'd0;
	localparam logic [1:0] OpWrite = 2'd1;
	localparam logic [1:0] OpPin   = 2'd2;

	localparam logic [1:0] KindData  = 2'd0;
	localparam logic [1:0] KindMode1 = 2'd1;
	localparam logic [1:0] KindMode0 = 2'd2;

	localparam logic [PortIdxW-1:0] IntPort = 3'd3;

	typedef logic [6:0] addr_t;
	typedef addr_t [2:0] addr_row_t;

	// Register offsets per port: data, M1, M0 (index 0 is data)
	localparam addr_row_t [PortSlots-1:0] AddrTable = '{
		'{7'h62, 7'h61, 7'h78},
		'{7'h4c, 7'h4b, 7'h68},
		'{7'h4a, 7'h49, 7'h48},
		'{7'h34, 7'h33, 7'h40},
		'{7'h32, 7'h31, 7'h30},
		'{7'h16, 7'h15, 7'h20},
		'{7'h12, 7'h11, 7'h10},
		'{7'h14, 7'h13, 7'h00}
	};

	typedef struct packed {
		logic       rmw_read;
		logic       pin_level;
		logic [5:0] pin_index;
		logic [7:0] write_data;
		logic [6:0] address;
		logic [1:0] op;
	} item_t;

	typedef struct packed {
		logic [1:0] int_levels;
		logic [7:0] port_levels;
		logic [2:0] levels_port;
		logic       levels_valid;
		logic       addr_hit;
		logic [7:0] read_data;
	} result_t;

	// Resolve pin levels from modes (m1,m0): 10 input, 01 latch, else latch AND input.
	function automatic logic [7:0] resolve_levels(input logic [7:0] m1, input logic [7:0] m0,
			input logic [7:0] lat, input logic [7:0] ext);
		logic [7:0] in_only;
		logic [7:0] push;
		logic [7:0] other;
		in_only = m1 & ~m0;
		push    = ~m1 & m0;
		other   = ~(in_only | push);
		return (in_only & ext) | (push & lat) | (other & lat & ext);
	endfunction

endpackage

@@ rtl/gpio_port_bank_with_pin_modes_unit.sv @@
// Bank of eight 8-bit I/O ports, each with a data latch and two pin-mode
// registers (M1, M0) in a 128-byte register window. Every input transaction
// is a register read (tuser 0), a register write (tuser 1) or an external pin
// change (tuser 2) and yields exactly one output transaction. Reads of a data
// register return the resolved pin levels, or the raw latch when rmw_read is
// set; writes to a mapped register and pin changes report that port's resolved
// levels and the INT0/INT1 levels (port 3 pins 2 and 3). Unmapped addresses
// read zero and drop writes. Timing: one transaction per cycle sustained; a
// transaction goes through the input register and then the result register,
// from which its result is offered on the output. While the output is held
// off, the two registers fill and the input stalls. Reset returns
// latches and inputs to all ones, M1 to 0xff (port 3: 0xfc) and M0 to zero.
module gpio_port_bank_with_pin_modes_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [6:0] address, [14:7] write_data, [20:15] pin_index, [21] pin_level,
	// [22] rmw_read, [23] zero
	input  logic [23:0] s_axis_tdata,
	// [1:0] op
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] read_data, [8] addr_hit, [9] levels_valid, [12:10] levels_port,
	// [20:13] port_levels, [22:21] int_levels, [23] zero
	output logic [23:0] m_axis_tdata
);
	import gpb_pkg::*;

	// Input register stage
	logic    item_valid_s1;
	item_t   item_s1;
	// Result register
	logic    res_valid_q;
	result_t res_q;

	// Port state
	logic [7:0] latch_q [PortSlots];
	logic [7:0] mode1_q [PortSlots];
	logic [7:0] mode0_q [PortSlots];
	logic [7:0] ext_q   [PortSlots];
	logic [7:0] latch_d [PortSlots];
	logic [7:0] mode1_d [PortSlots];
	logic [7:0] mode0_d [PortSlots];
	logic [7:0] ext_d   [PortSlots];

	logic                advance;
	logic                hit;
	logic [PortIdxW-1:0] hit_port;
	logic [1:0]          hit_kind;
	logic [PortIdxW-1:0] pin_port;
	logic                pin_mapped;
	logic [PortIdxW-1:0] rep_port;
	logic                rep_valid;
	result_t             res_d;

	// Advance the stage when the result register is free or being drained
	assign advance       = item_valid_s1 && (!res_valid_q || m_axis_tready);
	assign s_axis_tready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			item_valid_s1 <= s_axis_tvalid;
		end
	end

	// Capture the item on each accepted transaction
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.op         <= s_axis_tuser;
			item_s1.address    <= s_axis_tdata[6:0];
			item_s1.write_data <= s_axis_tdata[14:7];
			item_s1.pin_index  <= s_axis_tdata[20:15];
			item_s1.pin_level  <= s_axis_tdata[21];
			item_s1.rmw_read   <= s_axis_tdata[22];
		end
	end

	// Decode the address against the register map of mapped ports
	always_comb begin
		hit      = 1'b0;
		hit_port = '0;
		hit_kind = KindData;
		for (int p = 0; p < PortSlots; p++) begin
			for (int k = 0; k < 3; k++) begin
				if (p < PortCount && AddrTable[p][k] == item_s1.address) begin
					hit      = 1'b1;
					hit_port = PortIdxW'(p);
					hit_kind = 2'(k);
				end
			end
		end
	end

	assign pin_port   = item_s1.pin_index[5:3];
	assign pin_mapped = {1'b0, pin_port} < 4'(PortCount);

	// Next state: apply the register write or the pin change
	always_comb begin
		for (int p = 0; p < PortSlots; p++) begin
			latch_d[p] = latch_q[p];
			mode1_d[p] = mode1_q[p];
			mode0_d[p] = mode0_q[p];
			ext_d[p]   = ext_q[p];
		end
		unique case (item_s1.op)
			OpWrite: begin
				if (hit) begin
					unique case (hit_kind)
						KindData:  latch_d[hit_port] = item_s1.write_data;
						KindMode1: mode1_d[hit_port] = item_s1.write_data;
						KindMode0: mode0_d[hit_port] = item_s1.write_data;
						default:   ;
					endcase
				end
			end
			OpPin: begin
				if (pin_mapped) begin
					ext_d[pin_port][item_s1.pin_index[2:0]] = item_s1.pin_level;
				end
			end
			default: ;
		endcase
	end

	// Build the result from the updated state
	always_comb begin
		res_d     = '0;
		rep_port  = (item_s1.op == OpWrite) ? hit_port : pin_port;
		rep_valid = ((item_s1.op == OpWrite) && hit) || ((item_s1.op == OpPin) && pin_mapped);
		if ((item_s1.op == OpRead) && hit) begin
			res_d.addr_hit = 1'b1;
			unique case (hit_kind)
				KindData:  res_d.read_data = item_s1.rmw_read ? latch_d[hit_port] :
						resolve_levels(mode1_d[hit_port], mode0_d[hit_port],
							latch_d[hit_port], ext_d[hit_port]);
				KindMode1: res_d.read_data = mode1_d[hit_port];
				KindMode0: res_d.read_data = mode0_d[hit_port];
				default:   res_d.read_data = '0;
			endcase
		end
		if ((item_s1.op == OpWrite) && hit) begin
			res_d.addr_hit = 1'b1;
		end
		if (rep_valid) begin
			res_d.levels_valid = 1'b1;
			res_d.levels_port  = rep_port;
			res_d.port_levels  = resolve_levels(mode1_d[rep_port], mode0_d[rep_port],
					latch_d[rep_port], ext_d[rep_port]);
			if (PortCount > 3) begin
				res_d.int_levels = 2'(resolve_levels(mode1_d[IntPort], mode0_d[IntPort],
						latch_d[IntPort], ext_d[IntPort]) >> 2);
			end
		end
	end

	// Commit state as the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PortSlots; p++) begin
				latch_q[p] <= 8'hff;
				mode1_q[p] <= (PortIdxW'(p) == IntPort) ? 8'hfc : 8'hff;
				mode0_q[p] <= 8'h00;
				ext_q[p]   <= 8'hff;
			end
		end else if (advance) begin
			for (int p = 0; p < PortSlots; p++) begin
				latch_q[p] <= latch_d[p];
				mode1_q[p] <= mode1_d[p];
				mode0_q[p] <= mode0_d[p];
				ext_q[p]   <= ext_d[p];
			end
		end
	end

	// Hold the result until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = {1'b0, res_q};

endmodule
